>>> rtl/core/pipw_pkg.sv
package pipw_pkg;

	// Default geometry
	localparam int PIPW_COORD_BITS   = 16;
	localparam int PIPW_WINDING_BITS = 16;

	// Vertex tally saturates here; a polygon needs this many vertices
	localparam logic [1:0] TALLY_ONE  = 2'd1;
	localparam logic [1:0] TALLY_FULL = 2'd3;

	// Quadrant code, indexed [y negative][x negative]
	localparam logic [1:0] QUAD_MAP [2][2] = '{'{2'd0, 2'd1}, '{2'd3, 2'd2}};

	// Quadrant difference codes (current minus previous, 3-bit two's complement)
	localparam logic [2:0] QD_POS2 = 3'b010;
	localparam logic [2:0] QD_POS3 = 3'b011;
	localparam logic [2:0] QD_NEG3 = 3'b101;
	localparam logic [2:0] QD_NEG2 = 3'b110;

	// Winding steps
	localparam logic signed [1:0] STEP_UP   = 2'sb01;
	localparam logic signed [1:0] STEP_DOWN = 2'sb11;
	localparam logic signed [1:0] STEP_NONE = 2'sb00;

	// Per-item control carried down the pipeline
	typedef struct packed {
		logic first;   // opens a polygon
		logic last;    // closes a polygon, emits a result
		logic enough;  // at least three vertices seen so far
	} pipw_ctl_t;

	function automatic logic [1:0] quad_of(input logic neg_x, input logic neg_y);
		return QUAD_MAP[neg_y][neg_x];
	endfunction

	// Winding step for one edge from quadrant pq to quadrant cq
	function automatic logic signed [1:0] edge_step(input logic [1:0] pq,
			input logic [1:0] cq, input logic ccw);
		logic [2:0] diff;
		logic signed [1:0] step;
		diff = {1'b0, cq} - {1'b0, pq};
		case (diff)
			QD_NEG3: step = STEP_UP;
			QD_NEG2: step = ccw ? STEP_UP : STEP_NONE;
			QD_POS3: step = STEP_DOWN;
			QD_POS2: step = ccw ? STEP_NONE : STEP_DOWN;
			default: step = STEP_NONE;
		endcase
		return step;
	endfunction

endpackage

>>> rtl/core/pipw_if.sv
interface pipw_vtx_if import pipw_pkg::*; #(
	parameter int COORD_BITS = PIPW_COORD_BITS
);
	logic                         valid;
	logic                         ready;
	logic signed [COORD_BITS-1:0] point_x;
	logic signed [COORD_BITS-1:0] point_y;
	logic signed [COORD_BITS-1:0] vertex_x;
	logic signed [COORD_BITS-1:0] vertex_y;
	logic                         last_vertex;

	modport source (output valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
		input ready);
	modport sink (input valid, point_x, point_y, vertex_x, vertex_y, last_vertex,
		output ready);
endinterface

interface pipw_res_if;
	logic valid;
	logic ready;
	logic inside_res;
	logic too_few_vertices;

	modport source (output valid, inside_res, too_few_vertices, input ready);
	modport sink (input valid, inside_res, too_few_vertices, output ready);
endinterface

>>> rtl/core/pipw_offset.sv
module pipw_offset import pipw_pkg::*; #(
	parameter int COORD_BITS = PIPW_COORD_BITS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	pipw_vtx_if.sink                   vtx,
	input  logic                       rdy2,
	output logic                       vld1,
	output pipw_ctl_t                  ctl1,
	output logic signed [COORD_BITS:0] cur_x,
	output logic signed [COORD_BITS:0] cur_y,
	output logic signed [COORD_BITS:0] prev_x,
	output logic signed [COORD_BITS:0] prev_y,
	output logic signed [COORD_BITS:0] first_x,
	output logic signed [COORD_BITS:0] first_y,
	output logic [1:0]                 cur_q,
	output logic [1:0]                 prev_q,
	output logic [1:0]                 first_q
);

	logic                         valid_s1;
	logic signed [COORD_BITS-1:0] px_s1, py_s1, vx_s1, vy_s1;
	logic                         last_s1;

	logic                         awaiting_q;
	logic signed [COORD_BITS-1:0] held_x_q, held_y_q;
	logic signed [COORD_BITS:0]   first_x_q, first_y_q;
	logic signed [COORD_BITS:0]   prev_x_q, prev_y_q;
	logic [1:0]                   prev_q_q;
	logic [1:0]                   tally_q;

	logic                         accept, move;
	logic signed [COORD_BITS-1:0] use_x, use_y;
	logic [1:0]                   tally_next;

	assign vtx.ready = !valid_s1 || rdy2;
	assign accept    = vtx.valid && vtx.ready;
	assign move      = valid_s1 && rdy2;
	assign vld1      = valid_s1;

	// Input beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (vtx.ready) begin
			valid_s1 <= vtx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= vtx.point_x;
			py_s1   <= vtx.point_y;
			vx_s1   <= vtx.vertex_x;
			vy_s1   <= vtx.vertex_y;
			last_s1 <= vtx.last_vertex;
		end
	end

	// Offset from the test point; the point is sampled on the first vertex
	always_comb begin
		use_x   = awaiting_q ? px_s1 : held_x_q;
		use_y   = awaiting_q ? py_s1 : held_y_q;
		cur_x   = {vx_s1[COORD_BITS-1], vx_s1} - {use_x[COORD_BITS-1], use_x};
		cur_y   = {vy_s1[COORD_BITS-1], vy_s1} - {use_y[COORD_BITS-1], use_y};
		cur_q   = quad_of(cur_x[COORD_BITS], cur_y[COORD_BITS]);
		first_x = awaiting_q ? cur_x : first_x_q;
		first_y = awaiting_q ? cur_y : first_y_q;
		first_q = quad_of(first_x[COORD_BITS], first_y[COORD_BITS]);
		prev_x  = prev_x_q;
		prev_y  = prev_y_q;
		prev_q  = prev_q_q;
		if (awaiting_q) begin
			tally_next = TALLY_ONE;
		end else if (tally_q == TALLY_FULL) begin
			tally_next = TALLY_FULL;
		end else begin
			tally_next = tally_q + 2'd1;
		end
		ctl1.first  = awaiting_q;
		ctl1.last   = last_s1;
		ctl1.enough = (tally_next == TALLY_FULL);
	end

	// Polygon state, advanced as the beat leaves this stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			awaiting_q <= 1'b1;
			held_x_q   <= '0;
			held_y_q   <= '0;
			first_x_q  <= '0;
			first_y_q  <= '0;
			prev_x_q   <= '0;
			prev_y_q   <= '0;
			prev_q_q   <= '0;
			tally_q    <= '0;
		end else if (move) begin
			if (awaiting_q) begin
				held_x_q  <= px_s1;
				held_y_q  <= py_s1;
				first_x_q <= cur_x;
				first_y_q <= cur_y;
			end
			prev_x_q   <= cur_x;
			prev_y_q   <= cur_y;
			prev_q_q   <= cur_q;
			tally_q    <= tally_next;
			awaiting_q <= last_s1;
		end
	end

endmodule

>>> rtl/core/pipw_product.sv
module pipw_product import pipw_pkg::*; #(
	parameter int COORD_BITS = PIPW_COORD_BITS,
	localparam int PW = 2 * (COORD_BITS + 1)
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       vld1,
	input  pipw_ctl_t                  ctl1,
	input  logic signed [COORD_BITS:0] cur_x,
	input  logic signed [COORD_BITS:0] cur_y,
	input  logic signed [COORD_BITS:0] prev_x,
	input  logic signed [COORD_BITS:0] prev_y,
	input  logic signed [COORD_BITS:0] first_x,
	input  logic signed [COORD_BITS:0] first_y,
	input  logic [1:0]                 cur_q,
	input  logic [1:0]                 prev_q,
	input  logic [1:0]                 first_q,
	output logic                       rdy2,
	input  logic                       rdy3,
	output logic                       vld2,
	output pipw_ctl_t                  ctl2,
	output logic signed [PW-1:0]       edge_a,
	output logic signed [PW-1:0]       edge_b,
	output logic signed [PW-1:0]       close_a,
	output logic signed [PW-1:0]       close_b,
	output logic [1:0]                 cur_q2,
	output logic [1:0]                 prev_q2,
	output logic [1:0]                 first_q2
);

	logic                       valid_s2;
	pipw_ctl_t                  ctl_s2;
	logic signed [COORD_BITS:0] cx_s2, cy_s2, px_s2, py_s2, fx_s2, fy_s2;
	logic [1:0]                 cq_s2, pq_s2, fq_s2;

	assign rdy2 = !valid_s2 || rdy3;

	// Hold the offsets while downstream is busy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (rdy2) begin
			valid_s2 <= vld1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2 && vld1) begin
			ctl_s2 <= ctl1;
			cx_s2  <= cur_x;
			cy_s2  <= cur_y;
			px_s2  <= prev_x;
			py_s2  <= prev_y;
			fx_s2  <= first_x;
			fy_s2  <= first_y;
			cq_s2  <= cur_q;
			pq_s2  <= prev_q;
			fq_s2  <= first_q;
		end
	end

	// Cross-product terms: previous-to-current edge and current-to-first closing edge
	assign edge_a  = px_s2 * cy_s2;
	assign edge_b  = py_s2 * cx_s2;
	assign close_a = cx_s2 * fy_s2;
	assign close_b = cy_s2 * fx_s2;

	assign vld2     = valid_s2;
	assign ctl2     = ctl_s2;
	assign cur_q2   = cq_s2;
	assign prev_q2  = pq_s2;
	assign first_q2 = fq_s2;

endmodule

>>> rtl/core/pipw_wind.sv
module pipw_wind import pipw_pkg::*; #(
	parameter int COORD_BITS   = PIPW_COORD_BITS,
	parameter int WINDING_BITS = PIPW_WINDING_BITS,
	localparam int PW = 2 * (COORD_BITS + 1)
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld2,
	input  pipw_ctl_t            ctl2,
	input  logic signed [PW-1:0] edge_a,
	input  logic signed [PW-1:0] edge_b,
	input  logic signed [PW-1:0] close_a,
	input  logic signed [PW-1:0] close_b,
	input  logic [1:0]           cur_q2,
	input  logic [1:0]           prev_q2,
	input  logic [1:0]           first_q2,
	output logic                 rdy3,
	pipw_res_if.source           res
);

	logic                    valid_s3;
	pipw_ctl_t               ctl_s3;
	logic signed [PW-1:0]    ea_s3, eb_s3, ca_s3, cb_s3;
	logic [1:0]              cq_s3, pq_s3, fq_s3;

	logic [WINDING_BITS-1:0] wind_q;
	logic                    res_valid_q, inside_q, few_q;

	logic                    out_free, fire;
	logic signed [1:0]       step_edge, step_close;
	logic [WINDING_BITS-1:0] wind_base, wind_next;

	assign out_free = !res_valid_q || res.ready;
	assign fire     = valid_s3 && (!ctl_s3.last || out_free);
	assign rdy3     = !valid_s3 || fire;

	// Product register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (rdy3) begin
			valid_s3 <= vld2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3 && vld2) begin
			ctl_s3 <= ctl2;
			ea_s3  <= edge_a;
			eb_s3  <= edge_b;
			ca_s3  <= close_a;
			cb_s3  <= close_b;
			cq_s3  <= cur_q2;
			pq_s3  <= prev_q2;
			fq_s3  <= first_q2;
		end
	end

	// Combine the edge step and, on the final vertex, the closing step
	always_comb begin
		step_edge  = ctl_s3.first ? STEP_NONE : edge_step(pq_s3, cq_s3, ea_s3 >= eb_s3);
		step_close = ctl_s3.last ? edge_step(cq_s3, fq_s3, ca_s3 >= cb_s3) : STEP_NONE;
		wind_base  = ctl_s3.first ? '0 : wind_q;
		wind_next  = wind_base
			+ {{(WINDING_BITS-2){step_edge[1]}}, step_edge}
			+ {{(WINDING_BITS-2){step_close[1]}}, step_close};
	end

	// Winding count and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wind_q      <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				wind_q <= wind_next;
			end
			if (fire && ctl_s3.last) begin
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire && ctl_s3.last) begin
			inside_q <= ctl_s3.enough && (wind_next != '0);
			few_q    <= !ctl_s3.enough;
		end
	end

	assign res.valid            = res_valid_q;
	assign res.inside_res       = inside_q;
	assign res.too_few_vertices = few_q;

endmodule

>>> rtl/core/point_in_polygon_winding.sv
// Channel  Dir  Beat payload
// vtx      in   point_x, point_y, vertex_x, vertex_y, last_vertex
// res      out  inside_res, too_few_vertices (one beat per polygon)
//
// One vertex per cycle unless a held result beat stalls the pipeline.
// Stages: input register, offset subtract, cross-product multiplies, winding add.
// Reset returns the block to waiting for the first vertex of a polygon.
// Only a final vertex in the last stage waits on a full result register; the stages
// behind it fill and then hold vtx.ready low until the result beat is taken.
module point_in_polygon_winding import pipw_pkg::*; #(
	parameter int COORD_BITS   = PIPW_COORD_BITS,
	parameter int WINDING_BITS = PIPW_WINDING_BITS,
	localparam int PW = 2 * (COORD_BITS + 1)
) (
	input  logic       clk,
	input  logic       arst_n,
	pipw_vtx_if.sink   vtx,
	pipw_res_if.source res
);

	logic                       vld1, vld2, rdy2, rdy3;
	pipw_ctl_t                  ctl1, ctl2;
	logic signed [COORD_BITS:0] cur_x, cur_y, prev_x, prev_y, first_x, first_y;
	logic [1:0]                 cur_q, prev_q, first_q, cur_q2, prev_q2, first_q2;
	logic signed [PW-1:0]       edge_a, edge_b, close_a, close_b;

	pipw_offset #(.COORD_BITS(COORD_BITS)) u_offset (
		.clk     (clk),
		.arst_n  (arst_n),
		.vtx     (vtx),
		.rdy2    (rdy2),
		.vld1    (vld1),
		.ctl1    (ctl1),
		.cur_x   (cur_x),
		.cur_y   (cur_y),
		.prev_x  (prev_x),
		.prev_y  (prev_y),
		.first_x (first_x),
		.first_y (first_y),
		.cur_q   (cur_q),
		.prev_q  (prev_q),
		.first_q (first_q)
	);

	pipw_product #(.COORD_BITS(COORD_BITS)) u_product (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld1     (vld1),
		.ctl1     (ctl1),
		.cur_x    (cur_x),
		.cur_y    (cur_y),
		.prev_x   (prev_x),
		.prev_y   (prev_y),
		.first_x  (first_x),
		.first_y  (first_y),
		.cur_q    (cur_q),
		.prev_q   (prev_q),
		.first_q  (first_q),
		.rdy2     (rdy2),
		.rdy3     (rdy3),
		.vld2     (vld2),
		.ctl2     (ctl2),
		.edge_a   (edge_a),
		.edge_b   (edge_b),
		.close_a  (close_a),
		.close_b  (close_b),
		.cur_q2   (cur_q2),
		.prev_q2  (prev_q2),
		.first_q2 (first_q2)
	);

	pipw_wind #(.COORD_BITS(COORD_BITS), .WINDING_BITS(WINDING_BITS)) u_wind (
		.clk      (clk),
		.arst_n   (arst_n),
		.vld2     (vld2),
		.ctl2     (ctl2),
		.edge_a   (edge_a),
		.edge_b   (edge_b),
		.close_a  (close_a),
		.close_b  (close_b),
		.cur_q2   (cur_q2),
		.prev_q2  (prev_q2),
		.first_q2 (first_q2),
		.rdy3     (rdy3),
		.res      (res)
	);

endmodule

>>> rtl/core/pipw_chk.sv
module pipw_chk (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic inside_res,
	input logic too_few
);

	// A result is never both inside and short of vertices
	a_res_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(inside_res && too_few))
		else $error("result flags inside and too few at once");

	// Input stalls only come from a result beat that is not being taken
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output backpressure");

	// A waiting result beat holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> (out_valid && $stable(inside_res)
			&& $stable(too_few)))
		else $error("result beat changed while stalled");

endmodule

bind point_in_polygon_winding pipw_chk u_pipw_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (vtx.valid),
	.in_ready   (vtx.ready),
	.out_valid  (res.valid),
	.out_ready  (res.ready),
	.inside_res (res.inside_res),
	.too_few    (res.too_few_vertices)
);
